// ===== rtl/cfs_pkg.sv =====
// cfs_pkg: shared types, codes and helpers of the csv field splitter
// no dependencies; imported by every module in rtl/

package cfs_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam logic       QMODE_RESET = 1'b1;

  // results allowed per input beat
  localparam int unsigned        RCNT_W      = 4;
  localparam logic [RCNT_W-1:0]  MAX_RESULTS = 4'd12;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END_CELL = 2'd1,
    KIND_END_LINE = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EMPTY_LINE = 3'd1,
    ERR_UNCLOSED   = 3'd2,
    ERR_UNESCAPED  = 3'd3,
    ERR_OVERFLOW   = 3'd4
  } err_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SEPARATOR  = 1'b0,
    REG_QUOTE_MODE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] separator;
    logic       quote_mode;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] cell_byte;
    err_t       error_code;
  } result_t;

  // sequencer handshake toward the output stage
  typedef struct packed {
    logic step;
    logic done;
  } step_t;

  function automatic logic is_trim(input logic [7:0] b);
    return (b == 8'h0D) || (b == 8'h0A) || (b == 8'h0C) || (b == 8'h0B) ||
           (b == 8'hEF) || (b == 8'hBB) || (b == 8'hBF);
  endfunction

endpackage

// ===== rtl/cfs_cfg_regs.sv =====
// cfs_cfg_regs: apb register file holding separator and quote mode
// depends on cfs_pkg

module cfs_cfg_regs
  import cfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator  <= SEP_RESET;
      cfg.quote_mode <= QMODE_RESET;
    end else if (wr) begin
      case (idx)
        REG_SEPARATOR:  cfg.separator  <= pwdata[7:0];
        REG_QUOTE_MODE: cfg.quote_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEPARATOR:  prdata = {24'b0, cfg.separator};
      REG_QUOTE_MODE: prdata = {31'b0, cfg.quote_mode};
      default:        prdata = 32'b0;
    endcase
  end

endmodule

// ===== rtl/cfs_tokenizer.sv =====
// cfs_tokenizer: line state, trim hold memory and the per-beat sequencer
// depends on cfs_pkg; gives at most one result per step

module cfs_tokenizer
  import cfs_pkg::*;
#(
  parameter int TRIM_HOLD_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic [7:0] item_byte,
  input  logic       item_has,
  input  logic       item_eol,
  input  logic       step,
  output result_t    res,
  output logic       done
);

  localparam int CNT_W = $clog2(TRIM_HOLD_DEPTH + 1);
  localparam int IDX_W = (TRIM_HOLD_DEPTH > 1) ? $clog2(TRIM_HOLD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TRIM_HOLD_DEPTH);

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_FLUSH = 6'b000010,
    PH_BYTE  = 6'b000100,
    PH_EOC2  = 6'b001000,
    PH_FIN   = 6'b010000,
    PH_FIN2  = 6'b100000
  } phase_t;

  phase_t phase, phase_next;
  logic inside_quoted, inside_quoted_next;
  logic cell_start, cell_start_next;
  logic quote_pending, quote_pending_next;
  logic line_begun, line_begun_next;
  logic line_has_bytes, line_has_bytes_next;
  logic discarding, discarding_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [CNT_W-1:0] k, k_next, k_after;
  logic src_held, src_held_next;
  logic [RCNT_W-1:0] rcount;

  logic [7:0] held_mem [TRIM_HOLD_DEPTH];
  logic [7:0] held_q;
  logic [IDX_W-1:0] rd_addr;

  logic do_take, do_hold, do_fin, do_fin2, do_eoc2, two, take_src, src, clr, wr_en;
  logic [7:0] tb;
  logic emit;
  kind_t e_kind;
  logic [7:0] e_byte;
  err_t e_err;

  always_comb begin
    phase_next          = phase;
    inside_quoted_next  = inside_quoted;
    cell_start_next     = cell_start;
    quote_pending_next  = quote_pending;
    line_begun_next     = line_begun;
    line_has_bytes_next = line_has_bytes;
    discarding_next     = discarding;
    held_count_next     = held_count;
    k_next              = k;
    src_held_next       = src_held;
    k_after             = k;
    do_take = 1'b0; do_hold = 1'b0; do_fin = 1'b0; do_fin2 = 1'b0; do_eoc2 = 1'b0;
    two = 1'b0; take_src = 1'b0; src = 1'b0; clr = 1'b0; wr_en = 1'b0;
    tb = item_byte;
    emit = 1'b0; e_kind = KIND_BYTE; e_byte = 8'h00; e_err = ERR_NONE;
    done = 1'b0;

    case (phase)
      PH_START: begin
        if (item_has) line_has_bytes_next = 1'b1;
        if (item_has && !discarding) begin
          if (is_trim(item_byte)) begin
            do_hold = 1'b1;
          end else begin
            line_begun_next = 1'b1;
            if (held_count != '0) begin
              // go through the flush phase while the first held byte is fetched
              phase_next = PH_FLUSH;
              k_next     = '0;
            end else begin
              do_take = 1'b1;
            end
          end
        end else if (item_eol) begin
          do_fin = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      PH_FLUSH: begin
        do_take  = 1'b1;
        tb       = held_q;
        take_src = 1'b1;
      end
      PH_BYTE: do_take = 1'b1;
      PH_EOC2: do_eoc2 = 1'b1;
      PH_FIN:  do_fin  = 1'b1;
      PH_FIN2: do_fin2 = 1'b1;
      default: phase_next = PH_START;
    endcase

    if (do_hold) begin
      if (line_begun) begin
        if (held_count >= DEPTH_C) begin
          emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_OVERFLOW;
          discarding_next = 1'b1; inside_quoted_next = 1'b0;
          quote_pending_next = 1'b0; held_count_next = '0;
        end else begin
          wr_en           = 1'b1;
          held_count_next = held_count + CNT_W'(1);
        end
      end
      if (item_eol) phase_next = PH_FIN;
      else          done       = 1'b1;
    end

    if (do_take && !discarding) begin
      if (inside_quoted) begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          if (tb == QUOTE_BYTE) begin
            emit = 1'b1; e_byte = QUOTE_BYTE;
          end else if (tb == cfg.separator) begin
            // closing quote, end of cell follows in PH_EOC2
            emit = 1'b1; e_byte = QUOTE_BYTE;
            inside_quoted_next = 1'b0; cell_start_next = 1'b1; two = 1'b1;
          end else begin
            emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_UNESCAPED;
            discarding_next = 1'b1; inside_quoted_next = 1'b0;
            quote_pending_next = 1'b0; held_count_next = '0;
          end
        end else if (tb == QUOTE_BYTE) begin
          quote_pending_next = 1'b1;
        end else begin
          emit = 1'b1; e_byte = tb;
        end
      end else if (cfg.quote_mode && cell_start && tb == QUOTE_BYTE) begin
        inside_quoted_next = 1'b1; cell_start_next = 1'b0;
        emit = 1'b1; e_byte = QUOTE_BYTE;
      end else if (tb == cfg.separator) begin
        emit = 1'b1; e_kind = KIND_END_CELL; cell_start_next = 1'b1;
      end else begin
        emit = 1'b1; e_byte = tb; cell_start_next = 1'b0;
      end
    end

    if (do_eoc2) begin
      emit = 1'b1; e_kind = KIND_END_CELL;
    end

    if (do_take && two) begin
      phase_next    = PH_EOC2;
      src_held_next = take_src;
      if (take_src) k_next = k + CNT_W'(1);
    end else if (do_take || do_eoc2) begin
      src     = do_eoc2 ? src_held : take_src;
      k_after = do_eoc2 ? k : (k + CNT_W'(1));
      if (src && (k_after < held_count_next)) begin
        phase_next = PH_FLUSH;
        k_next     = k_after;
      end else if (src) begin
        held_count_next = '0;
        phase_next      = PH_BYTE;
      end else if (item_eol) begin
        phase_next = PH_FIN;
      end else begin
        done = 1'b1;
      end
    end

    if (do_fin) begin
      clr = 1'b1;
      if (!discarding) begin
        if (!line_has_bytes) begin
          emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_EMPTY_LINE;
        end else if (inside_quoted && !quote_pending) begin
          emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_UNCLOSED;
        end else if (inside_quoted) begin
          // pending quote closes the region at end of line
          emit = 1'b1; e_byte = QUOTE_BYTE;
          clr = 1'b0; phase_next = PH_FIN2;
        end else begin
          emit = 1'b1; e_kind = KIND_END_LINE;
        end
      end
    end

    if (do_fin2) begin
      emit = 1'b1; e_kind = KIND_END_LINE; clr = 1'b1;
    end

    if (clr) begin
      inside_quoted_next = 1'b0; cell_start_next = 1'b1; quote_pending_next = 1'b0;
      line_begun_next = 1'b0; line_has_bytes_next = 1'b0; discarding_next = 1'b0;
      held_count_next = '0;
      done = 1'b1;
    end

    if (done) phase_next = PH_START;
  end

  assign res.valid      = emit && (rcount < MAX_RESULTS);
  assign res.kind       = e_kind;
  assign res.cell_byte  = e_byte;
  assign res.error_code = e_err;

  assign rd_addr = step ? k_next[IDX_W-1:0] : k[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      inside_quoted  <= 1'b0;
      cell_start     <= 1'b1;
      quote_pending  <= 1'b0;
      line_begun     <= 1'b0;
      line_has_bytes <= 1'b0;
      discarding     <= 1'b0;
      held_count     <= '0;
      k              <= '0;
      src_held       <= 1'b0;
      rcount         <= '0;
    end else if (step) begin
      phase          <= phase_next;
      inside_quoted  <= inside_quoted_next;
      cell_start     <= cell_start_next;
      quote_pending  <= quote_pending_next;
      line_begun     <= line_begun_next;
      line_has_bytes <= line_has_bytes_next;
      discarding     <= discarding_next;
      held_count     <= held_count_next;
      k              <= k_next;
      src_held       <= src_held_next;
      if (done)           rcount <= '0;
      else if (res.valid) rcount <= rcount + RCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) held_mem[held_count[IDX_W-1:0]] <= item_byte;
    held_q <= held_mem[rd_addr];
  end

endmodule

// ===== rtl/cfs_out_stage.sv =====
// cfs_out_stage: holds one result until its last flag is known, then the output register
// depends on cfs_pkg

module cfs_out_stage
  import cfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  step_t       ctl,
  input  result_t     res,
  output logic        o_free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic    s_valid, s_final;
  result_t s_res;
  logic    load, move;
  kind_t   o_kind;
  logic [7:0] o_byte;
  err_t    o_err;

  assign o_free = !m_tvalid || m_tready;
  assign load   = ctl.step && res.valid;
  // staged result leaves once something proves whether it ends its beat
  assign move   = o_free && s_valid && (s_final || (ctl.step && (res.valid || ctl.done)));

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid  <= 1'b0;
      s_final  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        s_valid <= 1'b1;
        s_final <= ctl.done;
      end else if (move) begin
        s_valid <= 1'b0;
      end
      if (o_free) m_tvalid <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (load) s_res <= res;
    if (move) begin
      o_kind  <= s_res.kind;
      o_byte  <= s_res.cell_byte;
      o_err   <= s_res.error_code;
      m_tlast <= s_final || !load;
    end
  end

  assign m_tdata = {5'b0, o_err, o_byte};
  assign m_tuser = o_kind;

endmodule

// ===== rtl/csv_field_splitter.sv =====
// csv_field_splitter: top level of the csv cell splitter
// depends on cfs_pkg, cfs_cfg_regs, cfs_tokenizer, cfs_out_stage
//
//   channel   dir  fields
//   s_*       in   tdata data_byte, tuser carries_byte, tlast end_of_line
//   m_*       out  tdata cell_byte/error_code, tuser kind, tlast last result
//   apb       in   reg 0 separator at 0x0, reg 1 quote_mode at 0x4
//
// PH_START alone serves a plain byte, a held trim byte or a bare end of line; a byte
// with end of line goes on to PH_FIN, a closing quote before a separator to PH_EOC2,
// a quote closed by end of line to PH_FIN2, held trim bytes to PH_FLUSH (memory read)
// and PH_BYTE; results pass staging and output registers, at most one beat per cycle
// rst is synchronous and restores register defaults and an empty line; the hold
// memory is not cleared. m_tready low on a waiting beat freezes the sequencer and s_tready

module csv_field_splitter
  import cfs_pkg::*;
#(
  parameter int TRIM_HOLD_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] carries_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] cell_byte, [10:8] error_code, rest zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  result_t res;
  step_t   ctl;
  logic    o_free, done;
  logic    item_valid, item_has, item_eol;
  logic [7:0] item_byte;
  logic    accept;

  cfs_cfg_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign ctl.step = item_valid && o_free;
  assign ctl.done = done;
  assign s_tready = !item_valid || (ctl.step && done);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (ctl.step && done) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= s_tdata;
      item_has  <= s_tuser[0];
      item_eol  <= s_tlast;
    end
  end

  cfs_tokenizer #(.TRIM_HOLD_DEPTH(TRIM_HOLD_DEPTH)) u_tok (
    .clk, .rst, .cfg,
    .item_byte, .item_has, .item_eol,
    .step(ctl.step), .res, .done
  );

  cfs_out_stage u_out (
    .clk, .rst, .ctl, .res, .o_free,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

endmodule
